>>> src/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
package bba_pkg;

    // Number of tracking units in the arena and the order of the whole arena.
    localparam int UNITS      = 256;
    localparam int FULL_ORDER = 8;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    // One request transfer.
    typedef struct packed {
        logic        cmd;
        logic [15:0] request_bytes;
        logic [11:0] free_address;
    } bba_req_t;

    // One result transfer.
    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] user_address;
        logic [12:0] block_bytes;
    } bba_rsp_t;

    // Per-unit bookkeeping entry.
    typedef struct packed {
        logic       blk_start;
        logic       blk_taken;
        logic [3:0] blk_order;
    } bba_ent_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_NEXT,
        S_SPLIT,
        S_FREAD,
        S_FCHECK,
        S_MREAD,
        S_MCHECK,
        S_MLO
    } bba_state_t;

endpackage

>>> src/buddy_block_allocator.sv
// Buddy block allocator top level: unit table memory and its sequencer.
//
// The arena is tracked as 256 units held in a one-port-read, one-port-write
// table; a small sequencer walks that table one unit per cycle. A request
// transfer is taken when start is high and busy is low, and exactly one result
// is shown for one cycle with done high; the result cannot be held off. An
// allocate scans all 256 units for the best fit, then either splits the block
// (up to eight halvings, then marks the block taken) or, when the block needs
// no split, walks the table once more to find the next free block; it is
// refused when no block fits or when an exact fit is the only free block. An
// oversize request, like a malformed free address, never raises busy and shows
// its result in the cycle right after it is taken. A free reads and checks the
// block, releases it, then merges it with each equal free buddy in turn. Every
// other result is shown in the same cycle that busy falls.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int ARENA_BYTES  = 4096,
    parameter int HEADER_BYTES = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  bba_req_t request,
    output logic     busy,
    output logic     done,
    output bba_rsp_t result
);

    localparam int UNIT_BYTES = ARENA_BYTES / UNITS;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);

    bba_state_t state_reg, state_next;
    logic [8:0] cnt_reg, cnt_next;
    logic       pend_reg, pend_next;
    logic [3:0] k_reg, k_next;
    logic [7:0] best_reg, best_next;
    logic [3:0] bord_reg, bord_next;
    logic       found_reg, found_next;
    logic       nf_reg, nf_next;
    logic [1:0] nfree_reg, nfree_next;
    logic [3:0] o_reg, o_next;
    logic [7:0] cur_reg, cur_next;
    logic [7:0] head_reg, head_next;
    bba_rsp_t   res_reg, res_next;
    logic       done_reg, done_next;

    // Table storage and its ports.
    bba_ent_t   mem [UNITS];
    logic [UNITS-1:0] vld_reg;
    logic       rd_en;
    logic [7:0] rd_addr;
    logic       wr_en;
    logic [7:0] wr_addr;
    bba_ent_t   wr_data;
    bba_ent_t   rd_data_reg;
    logic       rd_vld_reg;
    logic [7:0] rd_addr_reg;
    bba_ent_t   rd_ent;
    logic       rd_free;

    // Request decode.
    logic [16:0] total;
    logic [3:0]  k_calc;
    logic        oversize;
    logic [31:0] addr32;
    logic [31:0] off32;
    logic        bad_free;
    logic [7:0]  free_unit;
    bba_rsp_t    alloc_rsp;
    bba_rsp_t    fail_rsp;
    logic [31:0] blk_bytes32;
    logic [31:0] free_bytes32;
    logic [31:0] user32;
    logic [7:0]  bud;

    // Table write port and read port with registered data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits: an unwritten entry reads as its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg  <= vld_reg[rd_addr];
                rd_addr_reg <= rd_addr;
            end
        end
    end

    // Decode the read entry, with the reset image for unwritten units.
    always_comb
    begin
        if (rd_vld_reg)
        begin
            rd_ent = rd_data_reg;
        end
        else
        begin
            rd_ent.blk_start = (rd_addr_reg == 8'd0);
            rd_ent.blk_taken = 1'b0;
            rd_ent.blk_order = (rd_addr_reg == 8'd0) ? 4'(FULL_ORDER) : 4'd0;
        end
        rd_free = rd_ent.blk_start && !rd_ent.blk_taken;
    end

    // Size class of an allocate: smallest order whose block holds request plus header.
    always_comb
    begin
        total    = {1'b0, request.request_bytes} + 17'(HEADER_BYTES);
        k_calc   = '0;
        oversize = 1'b1;
        for (int j = FULL_ORDER; j >= 0; j--)
        begin
            if ((32'(UNIT_BYTES) << j) >= 32'(total))
            begin
                k_calc   = 4'(j);
                oversize = 1'b0;
            end
        end
    end

    // Address checks of a free.
    always_comb
    begin
        addr32    = 32'(request.free_address);
        off32     = addr32 - 32'(HEADER_BYTES);
        bad_free  = (addr32 < 32'(HEADER_BYTES))
                    || ((off32 & 32'(UNIT_BYTES - 1)) != 32'd0)
                    || (off32 >= 32'(ARENA_BYTES));
        free_unit = 8'(off32 >> UNIT_SHIFT);
    end

    // Result words.
    always_comb
    begin
        blk_bytes32  = 32'(UNIT_BYTES) << k_reg;
        user32       = (32'(best_reg) << UNIT_SHIFT) + 32'(HEADER_BYTES);
        free_bytes32 = 32'(UNIT_BYTES) << rd_ent.blk_order;
        alloc_rsp.status       = ST_OK;
        alloc_rsp.user_address = user32[11:0];
        alloc_rsp.block_bytes  = blk_bytes32[12:0];
        fail_rsp.status        = ST_NO_BLOCK;
        fail_rsp.user_address  = '0;
        fail_rsp.block_bytes   = '0;
        bud = cur_reg ^ (8'd1 << o_reg[2:0]);
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            k_reg     <= '0;
            best_reg  <= '0;
            bord_reg  <= '0;
            found_reg <= 1'b0;
            nf_reg    <= 1'b0;
            nfree_reg <= '0;
            o_reg     <= '0;
            cur_reg   <= '0;
            head_reg  <= '0;
            res_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            k_reg     <= k_next;
            best_reg  <= best_next;
            bord_reg  <= bord_next;
            found_reg <= found_next;
            nf_reg    <= nf_next;
            nfree_reg <= nfree_next;
            o_reg     <= o_next;
            cur_reg   <= cur_next;
            head_reg  <= head_next;
            res_reg   <= res_next;
            done_reg  <= done_next;
        end
    end

    // Next state, table accesses and results.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        k_next     = k_reg;
        best_next  = best_reg;
        bord_next  = bord_reg;
        found_next = found_reg;
        nf_next    = nf_reg;
        nfree_next = nfree_reg;
        o_next     = o_reg;
        cur_next   = cur_reg;
        head_next  = head_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (request.cmd == CMD_ALLOC)
                    begin
                        if (oversize)
                        begin
                            res_next  = fail_rsp;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            k_next     = k_calc;
                            cnt_next   = '0;
                            bord_next  = 4'hF;
                            found_next = 1'b0;
                            nfree_next = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (bad_free)
                        begin
                            res_next.status       = ST_BAD_FREE;
                            res_next.user_address = '0;
                            res_next.block_bytes  = '0;
                            done_next             = 1'b1;
                        end
                        else
                        begin
                            cur_next   = free_unit;
                            state_next = S_FREAD;
                        end
                    end
                end
            end

            // Best-fit scan over all units from the head, one read per cycle.
            S_SCAN:
            begin
                if (pend_reg && rd_free)
                begin
                    if (nfree_reg != 2'd2)
                    begin
                        nfree_next = nfree_reg + 2'd1;
                    end
                    if (rd_ent.blk_order >= k_reg && rd_ent.blk_order < bord_reg)
                    begin
                        bord_next  = rd_ent.blk_order;
                        best_next  = rd_addr_reg;
                        found_next = 1'b1;
                    end
                end
                if (cnt_reg != 9'(UNITS))
                begin
                    rd_en     = 1'b1;
                    rd_addr   = head_reg + cnt_reg[7:0];
                    cnt_next  = cnt_reg + 9'd1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    if (!found_reg)
                    begin
                        res_next   = fail_rsp;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (bord_reg == k_reg)
                    begin
                        if (nfree_reg != 2'd2)
                        begin
                            res_next   = fail_rsp;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = best_reg;
                            wr_data    = '{blk_start: 1'b1, blk_taken: 1'b1,
                                           blk_order: k_reg};
                            cnt_next   = 9'd1;
                            nf_next    = 1'b0;
                            head_next  = best_reg;
                            state_next = S_NEXT;
                        end
                    end
                    else
                    begin
                        o_next     = bord_reg;
                        state_next = S_SPLIT;
                    end
                end
            end

            // Find the next free block above the one just taken.
            S_NEXT:
            begin
                if (pend_reg && rd_free && !nf_reg)
                begin
                    head_next = rd_addr_reg;
                    nf_next   = 1'b1;
                end
                if (cnt_reg != 9'(UNITS + 1))
                begin
                    rd_en     = 1'b1;
                    rd_addr   = best_reg + cnt_reg[7:0];
                    cnt_next  = cnt_reg + 9'd1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    res_next   = alloc_rsp;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // Halve the chosen block, freeing each right half, then mark the block taken.
            S_SPLIT:
            begin
                wr_en = 1'b1;
                if (o_reg > k_reg)
                begin
                    wr_addr = best_reg + (8'd1 << (o_reg[2:0] - 3'd1));
                    wr_data = '{blk_start: 1'b1, blk_taken: 1'b0,
                                blk_order: o_reg - 4'd1};
                    o_next  = o_reg - 4'd1;
                end
                else
                begin
                    wr_addr    = best_reg;
                    wr_data    = '{blk_start: 1'b1, blk_taken: 1'b1, blk_order: k_reg};
                    head_next  = best_reg + (8'd1 << k_reg[2:0]);
                    res_next   = alloc_rsp;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_FREAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = cur_reg;
                state_next = S_FCHECK;
            end

            // Validate the freed block and release it.
            S_FCHECK:
            begin
                if (!(rd_ent.blk_start && rd_ent.blk_taken))
                begin
                    res_next.status       = ST_BAD_FREE;
                    res_next.user_address = '0;
                    res_next.block_bytes  = '0;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = cur_reg;
                    wr_data = '{blk_start: 1'b1, blk_taken: 1'b0,
                                blk_order: rd_ent.blk_order};
                    o_next  = rd_ent.blk_order;
                    res_next.status       = ST_OK;
                    res_next.user_address = '0;
                    res_next.block_bytes  = free_bytes32[12:0];
                    state_next            = S_MREAD;
                end
            end

            // Read the buddy of the current block, unless it spans the arena.
            S_MREAD:
            begin
                if (o_reg >= 4'(FULL_ORDER))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = bud;
                    state_next = S_MCHECK;
                end
            end

            // Merge with a free equal-sized buddy: clear the upper start first.
            S_MCHECK:
            begin
                if (rd_free && rd_ent.blk_order == o_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = (cur_reg < bud) ? bud : cur_reg;
                    wr_data    = '0;
                    cur_next   = (cur_reg < bud) ? cur_reg : bud;
                    state_next = S_MLO;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_MLO:
            begin
                wr_en      = 1'b1;
                wr_addr    = cur_reg;
                wr_data    = '{blk_start: 1'b1, blk_taken: 1'b0, blk_order: o_reg + 4'd1};
                o_next     = o_reg + 4'd1;
                head_next  = cur_reg;
                state_next = S_MREAD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the buddy block allocator.
`timescale 1ns / 100ps

module testbench
    import bba_pkg::*;
();

    localparam int ARENA    = 4096;
    localparam int HDR      = 16;
    localparam int UNIT_B   = ARENA / UNITS;
    localparam int IDLE_MAX = 20000;
    localparam int DRAIN_CY = 600;

    logic     clk;
    logic     rst_n;
    logic     start;
    bba_req_t request;
    logic     busy;
    logic     done;
    bba_rsp_t result;

    // Shadow copy of the unit table and the scan head.
    logic       unit_start [UNITS];
    logic       unit_taken [UNITS];
    logic [3:0] unit_order [UNITS];
    logic [7:0] fit_head;

    bba_rsp_t      pending_rsp[$];
    logic [11:0]   live_addr[$];
    logic [11:0]   freed_addr[$];
    int            mismatches;
    int            idle_cycles;
    int            items_sent;
    int            results_seen;
    int            burst_left;
    int            n_alloc_ok, n_alloc_fail, n_free_ok, n_free_bad;

    buddy_block_allocator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit unit_is_free(input int u);
        logic [7:0] ui;
        ui = 8'(u);
        return unit_start[ui] && !unit_taken[ui];
    endfunction

    // Allocation model: best fit from the scan head, then split down.
    function automatic bba_rsp_t alloc_block(input logic [15:0] nbytes);
        bba_rsp_t r;
        int total, k, best, best_ord, u, nfree, o;
        bit found;
        r = '0;
        total = nbytes + HDR;
        k = 0;
        while (k <= FULL_ORDER && (UNIT_B << k) < total) k++;
        if (k > FULL_ORDER)
        begin
            r.status = ST_NO_BLOCK;
            return r;
        end
        found = 0;
        best = 0;
        best_ord = 255;
        for (int i = 0; i < UNITS; i++)
        begin
            u = (fit_head + i) % UNITS;
            if (unit_is_free(u) && unit_order[8'(u)] >= k && unit_order[8'(u)] < best_ord)
            begin
                best_ord = unit_order[8'(u)];
                best = u;
                found = 1;
            end
        end
        if (!found)
        begin
            r.status = ST_NO_BLOCK;
            return r;
        end
        if (best_ord == k)
        begin
            nfree = 0;
            for (int i = 0; i < UNITS; i++)
                if (unit_is_free(i)) nfree++;
            // The only free block is never handed out whole.
            if (nfree <= 1)
            begin
                r.status = ST_NO_BLOCK;
                return r;
            end
            unit_taken[8'(best)] = 1'b1;
            fit_head = best[7:0];
            for (int i = 1; i <= UNITS; i++)
                if (unit_is_free(best + i))
                begin
                    fit_head = 8'((best + i) % UNITS);
                    break;
                end
        end
        else
        begin
            for (o = best_ord; o > k; o--)
            begin
                u = (best + (1 << (o - 1))) % UNITS;
                unit_start[8'(u)] = 1'b1;
                unit_taken[8'(u)] = 1'b0;
                unit_order[8'(u)] = 4'(o - 1);
            end
            unit_order[8'(best)] = 4'(k);
            unit_taken[8'(best)] = 1'b1;
            fit_head = 8'((best + (1 << k)) % UNITS);
        end
        r.status       = ST_OK;
        r.user_address = 12'((best * UNIT_B + HDR) % 4096);
        r.block_bytes  = 13'((UNIT_B << k) % 8192);
        return r;
    endfunction

    // Release model: validate the address, then merge with equal free buddies.
    function automatic bba_rsp_t release_block(input logic [11:0] addr);
        bba_rsp_t r;
        int off, cur, o, bud, lo, hi;
        r = '0;
        r.status = ST_BAD_FREE;
        if (addr < HDR) return r;
        off = addr - HDR;
        if (off % UNIT_B != 0 || off >= ARENA) return r;
        cur = off / UNIT_B;
        if (!unit_start[8'(cur)] || !unit_taken[8'(cur)]) return r;
        unit_taken[8'(cur)] = 1'b0;
        o = unit_order[8'(cur)];
        r.status      = ST_OK;
        r.block_bytes = 13'((UNIT_B << o) % 8192);
        while (o < FULL_ORDER)
        begin
            bud = (cur ^ (1 << o)) % UNITS;
            if (!unit_is_free(bud) || unit_order[8'(bud)] != o) break;
            lo = cur < bud ? cur : bud;
            hi = cur < bud ? bud : cur;
            unit_start[8'(hi)] = 1'b0;
            unit_order[8'(hi)] = 4'd0;
            unit_order[8'(lo)] = 4'(o + 1);
            cur = lo;
            fit_head = lo[7:0];
            o++;
        end
        return r;
    endfunction

    task automatic report(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Work out the result of one accepted transfer and track live blocks.
    task automatic predict(input bba_req_t rq);
        bba_rsp_t r;
        int idx;
        if (rq.cmd == CMD_ALLOC)
        begin
            r = alloc_block(rq.request_bytes);
            if (r.status == ST_OK)
            begin
                live_addr.push_back(r.user_address);
                n_alloc_ok++;
            end
            else n_alloc_fail++;
        end
        else
        begin
            r = release_block(rq.free_address);
            if (r.status == ST_OK)
            begin
                idx = -1;
                foreach (live_addr[i])
                    if (live_addr[i] == rq.free_address) idx = i;
                if (idx >= 0) live_addr.delete(idx);
                freed_addr.push_back(rq.free_address);
                if (freed_addr.size() > 8) void'(freed_addr.pop_front());
                n_free_ok++;
            end
            else n_free_bad++;
        end
        pending_rsp.push_back(r);
    endtask

    // Send one transfer, with bursty gaps in front of it.
    task automatic send_item(input bba_req_t rq);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
        burst_left--;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= rq;
        do @(posedge clk); while (busy);
        predict(rq);
        items_sent++;
    endtask

    task automatic send_alloc(input logic [15:0] nbytes);
        bba_req_t rq;
        rq = '0;
        rq.cmd = CMD_ALLOC;
        rq.request_bytes = nbytes;
        rq.free_address = 12'($urandom);
        send_item(rq);
    endtask

    task automatic send_free(input logic [11:0] addr);
        bba_req_t rq;
        rq = '0;
        rq.cmd = CMD_FREE;
        rq.request_bytes = 16'($urandom);
        rq.free_address = addr;
        send_item(rq);
    endtask

    // Wait for every expected result, then let the block settle.
    task automatic quiesce();
        @(negedge clk);
        start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CY) @(posedge clk);
    endtask

    task automatic free_all_live();
        while (live_addr.size() != 0)
            send_free(live_addr[$urandom_range(0, live_addr.size() - 1)]);
    endtask

    // Field extremes, size rounding and every error path.
    task automatic test_directed();
        send_alloc(16'hffff);
        send_alloc(16'd4081);
        send_alloc(16'd4080);
        send_alloc(16'd0);
        send_alloc(16'd1);
        send_alloc(16'd17);
        send_alloc(16'd2032);
        send_alloc(16'd2048);
        send_free(12'd0);
        send_free(12'd15);
        send_free(12'd17);
        send_free(12'hfff);
        send_free(12'd48);
        send_free(12'd16);
        send_free(12'd16);
        free_all_live();
        send_alloc(16'd4080);
        quiesce();
    endtask

    // Fill the arena with equal blocks until it refuses, drain it, then allocate and drain again.
    task automatic test_fill_drain();
        for (int i = 0; i < 17; i++) send_alloc(16'd200);
        free_all_live();
        for (int i = 0; i < 6; i++) send_alloc(16'($urandom_range(0, 1000)));
        free_all_live();
        quiesce();
    endtask

    // Random mix of allocations, valid frees, double frees and noise.
    task automatic test_random_mix(input int n);
        int pick;
        logic [15:0] sz;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50 || live_addr.size() == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: sz = 16'($urandom_range(0, 40));
                    4, 5, 6:    sz = 16'($urandom_range(0, 300));
                    7, 8:       sz = 16'($urandom_range(0, 2100));
                    default:    sz = 16'($urandom);
                endcase
                send_alloc(sz);
            end
            else if (pick < 85)
                send_free(live_addr[$urandom_range(0, live_addr.size() - 1)]);
            else if (pick < 92 && freed_addr.size() != 0)
                send_free(freed_addr[$urandom_range(0, freed_addr.size() - 1)]);
            else
                send_free(12'($urandom));
        end
        free_all_live();
        quiesce();
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_rsp.size() == 0)
                report("result with nothing expected");
            else
            begin
                bba_rsp_t exp_r;
                exp_r = pending_rsp.pop_front();
                if (result.status !== exp_r.status)
                    report($sformatf("status %0d, expected %0d", result.status,
                                     exp_r.status));
                if (result.user_address !== exp_r.user_address)
                    report($sformatf("user_address %0d, expected %0d",
                                     result.user_address, exp_r.user_address));
                if (result.block_bytes !== exp_r.block_bytes)
                    report($sformatf("block_bytes %0d, expected %0d",
                                     result.block_bytes, exp_r.block_bytes));
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (done || (start && !busy && rst_n))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("watchdog expired after %0d quiet cycles", IDLE_MAX);
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        start   = 1'b0;
        request = '0;
        rst_n   = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        items_sent = 0;
        results_seen = 0;
        burst_left = 0;
        n_alloc_ok = 0;
        n_alloc_fail = 0;
        n_free_ok = 0;
        n_free_bad = 0;
        for (int i = 0; i < UNITS; i++)
        begin
            unit_start[8'(i)] = (i == 0);
            unit_taken[8'(i)] = 1'b0;
            unit_order[8'(i)] = (i == 0) ? 4'(FULL_ORDER) : 4'd0;
        end
        fit_head = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_fill_drain();
        test_random_mix(1550);

        $display("covered %0d transfers, %0d results: %0d allocations, %0d refused",
                 items_sent, results_seen, n_alloc_ok, n_alloc_fail);
        $display("frees: %0d accepted, %0d rejected", n_free_ok, n_free_bad);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
